FILE: hdl/xrg_pkg.sv
`default_nettype none

package xrg_pkg;

   localparam int UPC_W = 5;

   localparam logic [2:0] KIND_SEED   = 3'd0;
   localparam logic [2:0] KIND_LOAD   = 3'd1;
   localparam logic [2:0] KIND_LONG   = 3'd2;
   localparam logic [2:0] KIND_INT    = 3'd3;
   localparam logic [2:0] KIND_DOUBLE = 3'd4;

   localparam logic [63:0] SEED_GOLD  = 64'h9e3779b97f4a7c15;
   localparam logic [63:0] SEED_SQRT2 = 64'h6a09e667f3bcc909;
   localparam logic [63:0] MIX_MUL_A  = 64'hbf58476d1ce4e5b9;
   localparam logic [63:0] MIX_MUL_B  = 64'h94d049bb133111eb;

   // microcode step addresses
   localparam logic [UPC_W-1:0] UPC_IDLE      = 5'd0;
   localparam logic [UPC_W-1:0] UPC_SEED      = 5'd1;
   localparam logic [UPC_W-1:0] UPC_ROUND     = 5'd2;
   localparam logic [UPC_W-1:0] UPC_RND_MA0   = 5'd3;
   localparam logic [UPC_W-1:0] UPC_RND_MA1   = 5'd4;
   localparam logic [UPC_W-1:0] UPC_RND_MA2   = 5'd5;
   localparam logic [UPC_W-1:0] UPC_RND_MA3   = 5'd6;
   localparam logic [UPC_W-1:0] UPC_RND_XS27  = 5'd7;
   localparam logic [UPC_W-1:0] UPC_RND_MB0   = 5'd8;
   localparam logic [UPC_W-1:0] UPC_RND_MB1   = 5'd9;
   localparam logic [UPC_W-1:0] UPC_RND_MB2   = 5'd10;
   localparam logic [UPC_W-1:0] UPC_RND_MB3   = 5'd11;
   localparam logic [UPC_W-1:0] UPC_RND_XS31  = 5'd12;
   localparam logic [UPC_W-1:0] UPC_RND_STORE = 5'd13;
   localparam logic [UPC_W-1:0] UPC_LOAD      = 5'd14;
   localparam logic [UPC_W-1:0] UPC_LONG_D1   = 5'd15;
   localparam logic [UPC_W-1:0] UPC_LONG_EMIT = 5'd16;
   localparam logic [UPC_W-1:0] UPC_INT_D1    = 5'd17;
   localparam logic [UPC_W-1:0] UPC_INT_D2    = 5'd18;
   localparam logic [UPC_W-1:0] UPC_INT_MUL   = 5'd19;
   localparam logic [UPC_W-1:0] UPC_INT_LIM   = 5'd20;
   localparam logic [UPC_W-1:0] UPC_DIV_INIT  = 5'd21;
   localparam logic [UPC_W-1:0] UPC_DIV_STEP  = 5'd22;
   localparam logic [UPC_W-1:0] UPC_REJECT    = 5'd23;
   localparam logic [UPC_W-1:0] UPC_ZERO      = 5'd24;
   localparam logic [UPC_W-1:0] UPC_RE_D1     = 5'd25;
   localparam logic [UPC_W-1:0] UPC_RE_D2     = 5'd26;
   localparam logic [UPC_W-1:0] UPC_RE_MUL    = 5'd27;
   localparam logic [UPC_W-1:0] UPC_EMIT_PROD = 5'd28;
   localparam logic [UPC_W-1:0] UPC_EMIT_ZERO = 5'd29;

   typedef enum logic [2:0] {
      C_ALWAYS,
      C_FIRST,
      C_FREE,
      C_LIM,
      C_DIV_LAST,
      C_REJECT,
      C_ZERO
   } cond_type;

   typedef enum logic [1:0] {
      MA_NONE,
      MA_VLO,
      MA_VHI,
      MA_ACC
   } mul_a_type;

   typedef enum logic [2:0] {
      MB_ALO,
      MB_AHI,
      MB_BLO,
      MB_BHI,
      MB_BOUND
   } mul_b_type;

   typedef enum logic [2:0] {
      ACC_NONE,
      ACC_SET,
      ACC_ADDHI,
      ACC_ADD_V,
      ACC_DRAW
   } acc_op_type;

   typedef enum logic [2:0] {
      V_NONE,
      V_SEED,
      V_XS30,
      V_XS27,
      V_XS31,
      V_H,
      V_SLO
   } v_op_type;

   typedef enum logic [1:0] {
      S_NONE,
      S_LOAD,
      S_MIX_STORE,
      S_STEP
   } s_op_type;

   typedef enum logic [1:0] {
      DV_NONE,
      DV_INIT,
      DV_STEP
   } div_op_type;

   typedef enum logic [1:0] {
      O_NONE,
      O_SUM,
      O_PROD,
      O_ZERO
   } out_op_type;

   typedef struct packed {
      cond_type         cond;
      logic [UPC_W-1:0] next_t;
      logic [UPC_W-1:0] next_f;
      mul_a_type        mul_a;
      mul_b_type        mul_b;
      acc_op_type       acc_op;
      v_op_type         v_op;
      s_op_type         s_op;
      div_op_type       div_op;
      out_op_type       out_op;
   } ctl_word_type;

   localparam ctl_word_type CW_NOP = '{
      cond: C_ALWAYS, next_t: UPC_IDLE, next_f: UPC_IDLE, mul_a: MA_NONE, mul_b: MB_ALO,
      acc_op: ACC_NONE, v_op: V_NONE, s_op: S_NONE, div_op: DV_NONE, out_op: O_NONE};

   function automatic logic [UPC_W-1:0] dispatch(input logic [2:0] kind);
      logic [UPC_W-1:0] upc;
      case (kind)
         KIND_SEED:   upc = UPC_SEED;
         KIND_LOAD:   upc = UPC_LOAD;
         KIND_LONG:   upc = UPC_LONG_D1;
         KIND_INT:    upc = UPC_INT_D1;
         KIND_DOUBLE: upc = UPC_LONG_D1;
         default:     upc = UPC_IDLE;
      endcase
      return upc;
   endfunction

   function automatic ctl_word_type ucode_rom(input logic [UPC_W-1:0] upc);
      ctl_word_type w;
      w = CW_NOP;
      case (upc)
         UPC_SEED: begin
            w.v_op = V_SEED;
            w.next_t = UPC_ROUND;
         end
         UPC_ROUND: begin
            w.v_op = V_XS30;
            w.next_t = UPC_RND_MA0;
         end
         UPC_RND_MA0: begin
            w.mul_a = MA_VLO;
            w.mul_b = MB_ALO;
            w.next_t = UPC_RND_MA1;
         end
         UPC_RND_MA1: begin
            w.acc_op = ACC_SET;
            w.mul_a = MA_VLO;
            w.mul_b = MB_AHI;
            w.next_t = UPC_RND_MA2;
         end
         UPC_RND_MA2: begin
            w.acc_op = ACC_ADDHI;
            w.mul_a = MA_VHI;
            w.mul_b = MB_ALO;
            w.next_t = UPC_RND_MA3;
         end
         UPC_RND_MA3: begin
            w.acc_op = ACC_ADDHI;
            w.next_t = UPC_RND_XS27;
         end
         UPC_RND_XS27: begin
            w.v_op = V_XS27;
            w.next_t = UPC_RND_MB0;
         end
         UPC_RND_MB0: begin
            w.mul_a = MA_VLO;
            w.mul_b = MB_BLO;
            w.next_t = UPC_RND_MB1;
         end
         UPC_RND_MB1: begin
            w.acc_op = ACC_SET;
            w.mul_a = MA_VLO;
            w.mul_b = MB_BHI;
            w.next_t = UPC_RND_MB2;
         end
         UPC_RND_MB2: begin
            w.acc_op = ACC_ADDHI;
            w.mul_a = MA_VHI;
            w.mul_b = MB_BLO;
            w.next_t = UPC_RND_MB3;
         end
         UPC_RND_MB3: begin
            w.acc_op = ACC_ADDHI;
            w.next_t = UPC_RND_XS31;
         end
         UPC_RND_XS31: begin
            w.v_op = V_XS31;
            w.next_t = UPC_RND_STORE;
         end
         UPC_RND_STORE: begin
            w.s_op = S_MIX_STORE;
            w.v_op = V_H;
            w.cond = C_FIRST;
            w.next_t = UPC_ROUND;
            w.next_f = UPC_IDLE;
         end
         UPC_LOAD: begin
            w.s_op = S_LOAD;
         end
         UPC_LONG_D1: begin
            w.s_op = S_STEP;
            w.acc_op = ACC_DRAW;
            w.v_op = V_SLO;
            w.next_t = UPC_LONG_EMIT;
         end
         UPC_LONG_EMIT: begin
            w.out_op = O_SUM;
            w.cond = C_FREE;
            w.next_t = UPC_IDLE;
            w.next_f = UPC_LONG_EMIT;
         end
         UPC_INT_D1: begin
            w.s_op = S_STEP;
            w.acc_op = ACC_DRAW;
            w.v_op = V_SLO;
            w.next_t = UPC_INT_D2;
         end
         UPC_INT_D2: begin
            w.acc_op = ACC_ADD_V;
            w.next_t = UPC_INT_MUL;
         end
         UPC_INT_MUL: begin
            w.mul_a = MA_ACC;
            w.mul_b = MB_BOUND;
            w.next_t = UPC_INT_LIM;
         end
         UPC_INT_LIM: begin
            w.cond = C_LIM;
            w.next_t = UPC_DIV_INIT;
            w.next_f = UPC_EMIT_PROD;
         end
         UPC_DIV_INIT: begin
            w.div_op = DV_INIT;
            w.next_t = UPC_DIV_STEP;
         end
         UPC_DIV_STEP: begin
            w.div_op = DV_STEP;
            w.cond = C_DIV_LAST;
            w.next_t = UPC_REJECT;
            w.next_f = UPC_DIV_STEP;
         end
         UPC_REJECT: begin
            w.cond = C_REJECT;
            w.next_t = UPC_ZERO;
            w.next_f = UPC_EMIT_PROD;
         end
         UPC_ZERO: begin
            w.cond = C_ZERO;
            w.next_t = UPC_EMIT_ZERO;
            w.next_f = UPC_RE_D1;
         end
         UPC_RE_D1: begin
            w.s_op = S_STEP;
            w.acc_op = ACC_DRAW;
            w.v_op = V_SLO;
            w.next_t = UPC_RE_D2;
         end
         UPC_RE_D2: begin
            w.acc_op = ACC_ADD_V;
            w.next_t = UPC_RE_MUL;
         end
         UPC_RE_MUL: begin
            w.mul_a = MA_ACC;
            w.mul_b = MB_BOUND;
            w.next_t = UPC_REJECT;
         end
         UPC_EMIT_PROD: begin
            w.out_op = O_PROD;
            w.cond = C_FREE;
            w.next_t = UPC_IDLE;
            w.next_f = UPC_EMIT_PROD;
         end
         UPC_EMIT_ZERO: begin
            w.out_op = O_ZERO;
            w.cond = C_FREE;
            w.next_t = UPC_IDLE;
            w.next_f = UPC_EMIT_ZERO;
         end
         default: begin
            w = CW_NOP;
         end
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

FILE: hdl/xoroshiro_random_generator.sv
`default_nettype none

// Xoroshiro128++ generator with seeding, raw state load and long, double and
// bounded int draws. A 30-step microcode table drives one datapath with a
// single registered 32x32 multiplier and a one-bit-per-cycle remainder unit.
// A word is taken only while the sequencer sits at its idle step. Then load
// copies the raw state, long or double draw and emit, seed runs two mixing
// rounds of 12 steps (each 64-bit multiply done as three 32x32 partial
// products), and bounded int draws and multiplies, with the rejection
// threshold remainder computed once when the low product falls below the
// bound and a redraw per rejection. Kinds 5 to 7 are taken and dropped. A
// result waits in an output register; the next word is accepted while it waits,
// and its emit step holds for as long as the waiting result is stalled.
module xoroshiro_random_generator
   import xrg_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_stall,
   input  wire logic [2:0]  req_kind,
   input  wire logic [63:0] req_word_low,
   input  wire logic [63:0] req_word_high,
   input  wire logic [31:0] req_bound,
   output      logic        rsp_valid,
   input  wire logic        rsp_stall,
   output      logic [63:0] rsp_value
);

   logic [UPC_W-1:0] pc_ff, pc_in;
   logic [63:0]      wl_ff, wl_in;
   logic [63:0]      wh_ff, wh_in;
   logic [31:0]      bound_ff, bound_in;
   logic             dbl_ff, dbl_in;
   logic [63:0]      s_lo_ff, s_lo_in;
   logic [63:0]      s_hi_ff, s_hi_in;
   logic [63:0]      v_ff, v_in;
   logic [63:0]      h_ff, h_in;
   logic [63:0]      acc_ff, acc_in;
   logic [63:0]      prod_ff, prod_in;
   logic             phase_ff, phase_in;
   logic [31:0]      rem_ff, rem_in;
   logic [31:0]      dvd_ff, dvd_in;
   logic [4:0]       cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [63:0]      rsp_value_ff, rsp_value_in;

   ctl_word_type cw;
   logic         accept;
   logic         free;
   logic         cond_ok;
   logic [31:0]  mul_a;
   logic [31:0]  mul_b;
   logic [63:0]  draw_sum;
   logic [63:0]  draw_rot;
   logic [63:0]  bx;
   logic [63:0]  sum_av;
   logic [63:0]  seed_l;
   logic [32:0]  rem_try;
   logic [32:0]  rem_sub;

   assign cw       = ucode_rom(pc_ff);
   assign accept   = req_valid && (pc_ff == UPC_IDLE);
   assign free     = !rsp_valid_ff || !rsp_stall;
   assign draw_sum = s_lo_ff + s_hi_ff;
   assign draw_rot = {draw_sum[46:0], draw_sum[63:47]};
   assign bx       = s_lo_ff ^ s_hi_ff;
   assign sum_av   = acc_ff + v_ff;
   assign seed_l   = wl_ff ^ SEED_SQRT2;
   assign rem_try  = {rem_ff, dvd_ff[31]};
   assign rem_sub  = rem_try - {1'b0, bound_ff};

   assign req_stall = (pc_ff != UPC_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_value = rsp_value_ff;

   // condition select
   always_comb begin
      case (cw.cond)
         C_ALWAYS:   cond_ok = 1'b1;
         C_FIRST:    cond_ok = !phase_ff;
         C_FREE:     cond_ok = free;
         C_LIM:      cond_ok = (prod_ff[31:0] < bound_ff);
         C_DIV_LAST: cond_ok = (cnt_ff == '1);
         C_REJECT:   cond_ok = (prod_ff[31:0] < rem_ff);
         C_ZERO:     cond_ok = ((s_lo_ff | s_hi_ff) == 64'd0);
         default:    cond_ok = 1'b1;
      endcase
   end

   // multiplier operands
   always_comb begin
      case (cw.mul_a)
         MA_VLO:  mul_a = v_ff[31:0];
         MA_VHI:  mul_a = v_ff[63:32];
         MA_ACC:  mul_a = acc_ff[31:0];
         default: mul_a = 32'd0;
      endcase
      case (cw.mul_b)
         MB_ALO:   mul_b = MIX_MUL_A[31:0];
         MB_AHI:   mul_b = MIX_MUL_A[63:32];
         MB_BLO:   mul_b = MIX_MUL_B[31:0];
         MB_BHI:   mul_b = MIX_MUL_B[63:32];
         MB_BOUND: mul_b = bound_ff;
         default:  mul_b = 32'd0;
      endcase
   end

   always_comb begin
      pc_in        = pc_ff;
      wl_in        = wl_ff;
      wh_in        = wh_ff;
      bound_in     = bound_ff;
      dbl_in       = dbl_ff;
      s_lo_in      = s_lo_ff;
      s_hi_in      = s_hi_ff;
      v_in         = v_ff;
      h_in         = h_ff;
      acc_in       = acc_ff;
      prod_in      = prod_ff;
      phase_in     = phase_ff;
      rem_in       = rem_ff;
      dvd_in       = dvd_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_value_in = rsp_value_ff;

      // sequencer
      if (pc_ff == UPC_IDLE) begin
         if (accept) begin
            pc_in    = dispatch(req_kind);
            wl_in    = req_word_low;
            wh_in    = req_word_high;
            bound_in = req_bound;
            dbl_in   = (req_kind == KIND_DOUBLE);
         end
      end else begin
         pc_in = cond_ok ? cw.next_t : cw.next_f;
      end

      if (cw.mul_a != MA_NONE) begin
         prod_in = {32'd0, mul_a} * {32'd0, mul_b};
      end

      case (cw.acc_op)
         ACC_SET:   acc_in = prod_ff;
         ACC_ADDHI: acc_in = {acc_ff[63:32] + prod_ff[31:0], acc_ff[31:0]};
         ACC_ADD_V: acc_in = sum_av;
         ACC_DRAW:  acc_in = draw_rot;
         default:   acc_in = acc_ff;
      endcase

      case (cw.v_op)
         V_SEED: begin
            v_in     = seed_l;
            h_in     = seed_l + SEED_GOLD;
            phase_in = 1'b0;
         end
         V_XS30:  v_in = v_ff ^ (v_ff >> 30);
         V_XS27:  v_in = acc_ff ^ (acc_ff >> 27);
         V_XS31:  v_in = acc_ff ^ (acc_ff >> 31);
         V_H:     v_in = h_ff;
         V_SLO:   v_in = s_lo_ff;
         default: v_in = v_ff;
      endcase

      case (cw.s_op)
         S_LOAD: begin
            s_lo_in = wl_ff;
            s_hi_in = wh_ff;
         end
         S_MIX_STORE: begin
            if (!phase_ff) begin
               s_lo_in = v_ff;
            end else begin
               s_hi_in = v_ff;
            end
            phase_in = !phase_ff;
         end
         S_STEP: begin
            s_lo_in = {s_lo_ff[14:0], s_lo_ff[63:15]} ^ bx ^ (bx << 21);
            s_hi_in = {bx[35:0], bx[63:36]};
         end
         default: begin
            s_lo_in = s_lo_ff;
         end
      endcase

      // restoring remainder, one dividend bit per step
      case (cw.div_op)
         DV_INIT: begin
            rem_in = 32'd0;
            dvd_in = 32'd0 - bound_ff;
            cnt_in = 5'd0;
         end
         DV_STEP: begin
            rem_in = rem_sub[32] ? rem_try[31:0] : rem_sub[31:0];
            dvd_in = {dvd_ff[30:0], 1'b0};
            cnt_in = cnt_ff + 5'd1;
         end
         default: begin
            rem_in = rem_ff;
         end
      endcase

      if ((cw.out_op != O_NONE) && free) begin
         rsp_valid_in = 1'b1;
         case (cw.out_op)
            O_SUM:   rsp_value_in = dbl_ff ? {11'd0, sum_av[63:11]} : sum_av;
            O_PROD:  rsp_value_in = {32'd0, prod_ff[63:32]};
            default: rsp_value_in = 64'd0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= UPC_IDLE;
         s_lo_ff      <= 64'd0;
         s_hi_ff      <= 64'd0;
         phase_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pc_ff        <= pc_in;
         s_lo_ff      <= s_lo_in;
         s_hi_ff      <= s_hi_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      wl_ff        <= wl_in;
      wh_ff        <= wh_in;
      bound_ff     <= bound_in;
      dbl_ff       <= dbl_in;
      v_ff         <= v_in;
      h_ff         <= h_in;
      acc_ff       <= acc_in;
      prod_ff      <= prod_in;
      rem_ff       <= rem_in;
      dvd_ff       <= dvd_in;
      cnt_ff       <= cnt_in;
      rsp_value_ff <= rsp_value_in;
   end

endmodule

`default_nettype wire
